// ----- hdl/hsvrgb_pkg.sv -----
`timescale 1ns / 1ps

package hsvrgb_pkg;

    // Field widths of one word on either side.
    localparam int HUE_W    = 9;
    localparam int LEVEL_W  = 8;
    localparam int SECTOR_W = 4;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = 2 * LEVEL_W;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 24;

    localparam int SECTOR_DEGREES = 60;
    localparam int LAST_SECTOR    = 8;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 8'd255;

    typedef logic [SECTOR_W-1:0] t_sector;
    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [PROD_W-1:0]   t_prod;

    // Hue sectors; every code from five upward shares the magenta-to-red order.
    localparam t_sector SEC_RED_YEL = 4'd0;
    localparam t_sector SEC_YEL_GRN = 4'd1;
    localparam t_sector SEC_GRN_CYN = 4'd2;
    localparam t_sector SEC_CYN_BLU = 4'd3;
    localparam t_sector SEC_BLU_MAG = 4'd4;

    // Truncating division by 255 for products of two bytes (at most 65025).
    function automatic t_level div255(input t_prod x);
        logic [PROD_W:0] sum;
        sum = {1'b0, x} + {{(LEVEL_W + 1){1'b0}}, x[PROD_W-1:LEVEL_W]} + 17'd1;
        return sum[PROD_W-1:LEVEL_W];
    endfunction

endpackage

// ----- hdl/hsv_to_rgb_converter_unit.sv -----
`timescale 1ns / 1ps

// HSV to RGB converter, 8-bit integer form. Each input word carries a hue in
// degrees, a saturation and a value; each output word carries red, green and
// blue. Zero saturation gives the value on all three channels. Hues from 360
// up fall into the last arrangement, the same one as sector five. The block
// is a five-stage pipeline that takes one word every clock cycle when the
// output side does not stall. The multiplier stages set that depth: every
// byte product is registered before its division by 255, and the second
// pair of products needs the first quotients. Each stage holds its own
// valid bit and loads whenever it is empty or the stage after it moves, so a
// stall on the output side fills bubbles first and then holds every stage
// without losing or repeating words.
module hsv_to_rgb_converter_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave side. tdata: hue [8:0], saturation [16:9], brightness [24:17],
    // zero fill [31:25].
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [hsvrgb_pkg::S_DATA_W-1:0]   i_s_tdata,
    // Master side. tdata: red [7:0], green [15:8], blue [23:16].
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [hsvrgb_pkg::M_DATA_W-1:0]   o_m_tdata
);
    import hsvrgb_pkg::*;

    // Stage enables, computed from the output back toward the input.
    logic en1, en2, en3, en4, en5;

    // Stage 1: sector, fraction, saturation, value.
    logic    r1_vld;
    t_sector r1_sector;
    t_level  r1_f;
    t_level  r1_s;
    t_level  r1_v;

    // Stage 2: first products.
    logic    r2_vld;
    t_sector r2_sector;
    t_level  r2_v;
    logic    r2_grey;
    t_prod   r2_prod_q;
    t_prod   r2_prod_t;
    t_prod   r2_prod_p;

    // Stage 3: quotients of the first products.
    logic    r3_vld;
    t_sector r3_sector;
    t_level  r3_v;
    logic    r3_grey;
    t_level  r3_kq;
    t_level  r3_kt;
    t_level  r3_p;

    // Stage 4: second products.
    logic    r4_vld;
    t_sector r4_sector;
    t_level  r4_v;
    logic    r4_grey;
    t_prod   r4_prod_q;
    t_prod   r4_prod_t;
    t_level  r4_p;

    // Stage 5: output register.
    logic    r5_vld;
    t_level  r5_red;
    t_level  r5_green;
    t_level  r5_blue;

    // Hue decode for stage 1.
    logic [HUE_W-1:0]  hue;
    t_sector           n_sector;
    logic [HUE_W-1:0]  sector_base;
    logic [HUE_W-1:0]  hue_rem;
    logic [FRAC_W+1:0] frac_x17;

    // Final selection for stage 5.
    t_level q_lvl;
    t_level t_lvl;
    t_level n_red;
    t_level n_green;
    t_level n_blue;

    assign en5 = !r5_vld || i_m_tready;
    assign en4 = !r4_vld || en5;
    assign en3 = !r3_vld || en4;
    assign en2 = !r2_vld || en3;
    assign en1 = !r1_vld || en2;

    assign o_s_tready = en1;
    assign o_m_tvalid = r5_vld;
    assign o_m_tdata  = {r5_blue, r5_green, r5_red};

    assign hue = i_s_tdata[HUE_W-1:0];

    // The sector is the count of 60-degree boundaries the hue has passed,
    // and the remainder is what is left above the last one.
    always_comb begin
        n_sector    = '0;
        sector_base = '0;
        for (int k = 1; k <= LAST_SECTOR; k++) begin
            if (hue >= HUE_W'(k * SECTOR_DEGREES)) begin
                n_sector    = SECTOR_W'(k);
                sector_base = HUE_W'(k * SECTOR_DEGREES);
            end
        end
        hue_rem  = hue - sector_base;
        // rem * 255 / 60 equals rem * 17 / 4.
        frac_x17 = {hue_rem[5:0], 4'd0} + {4'd0, hue_rem[5:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else begin
            if (en1) r1_vld <= i_s_tvalid;
            if (en2) r2_vld <= r1_vld;
            if (en3) r3_vld <= r2_vld;
            if (en4) r4_vld <= r3_vld;
            if (en5) r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_sector <= n_sector;
            r1_f      <= frac_x17[FRAC_W+1:2];
            r1_s      <= i_s_tdata[HUE_W +: LEVEL_W];
            r1_v      <= i_s_tdata[HUE_W + LEVEL_W +: LEVEL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_sector <= r1_sector;
            r2_v      <= r1_v;
            r2_grey   <= (r1_s == '0);
            r2_prod_q <= r1_s * r1_f;
            r2_prod_t <= r1_s * (FULL_SCALE - r1_f);
            r2_prod_p <= r1_v * (FULL_SCALE - r1_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_sector <= r2_sector;
            r3_v      <= r2_v;
            r3_grey   <= r2_grey;
            r3_kq     <= div255(r2_prod_q);
            r3_kt     <= div255(r2_prod_t);
            r3_p      <= div255(r2_prod_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_sector <= r3_sector;
            r4_v      <= r3_v;
            r4_grey   <= r3_grey;
            r4_prod_q <= r3_v * (FULL_SCALE - r3_kq);
            r4_prod_t <= r3_v * (FULL_SCALE - r3_kt);
            r4_p      <= r3_p;
        end
    end

    // The sector picks the channel order; grey overrides it.
    always_comb begin
        q_lvl = div255(r4_prod_q);
        t_lvl = div255(r4_prod_t);
        if (r4_grey) begin
            n_red   = r4_v;
            n_green = r4_v;
            n_blue  = r4_v;
        end else begin
            unique case (r4_sector)
                SEC_RED_YEL: begin
                    n_red = r4_v;  n_green = t_lvl; n_blue = r4_p;
                end
                SEC_YEL_GRN: begin
                    n_red = q_lvl; n_green = r4_v;  n_blue = r4_p;
                end
                SEC_GRN_CYN: begin
                    n_red = r4_p;  n_green = r4_v;  n_blue = t_lvl;
                end
                SEC_CYN_BLU: begin
                    n_red = r4_p;  n_green = q_lvl; n_blue = r4_v;
                end
                SEC_BLU_MAG: begin
                    n_red = t_lvl; n_green = r4_p;  n_blue = r4_v;
                end
                default: begin
                    n_red = r4_v;  n_green = r4_p;  n_blue = q_lvl;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_red   <= n_red;
            r5_green <= n_green;
            r5_blue  <= n_blue;
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

// Checks the HSV to RGB pipeline against a behavioral predictor. Each accepted
// input word is converted on the spot and queued, and every output word is
// compared, channel by channel, with the oldest queued color. The stimulus runs
// from directed corner colors, through a long random stream with gaps on both
// sides, a long output stall that fills the pipeline, and a full-rate tail.
module testbench;

    import hsvrgb_pkg::*;

    localparam int CLK_HALF_NS      = 2;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_WORDS     = 1250;
    localparam int STALL_WORDS      = 80;
    localparam int FULL_RATE_WORDS  = 250;
    localparam int SINK_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES     = 20;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_REPORTS      = 10;
    localparam int HUE_LAST         = 359;
    localparam int HUE_TOP          = (1 << HUE_W) - 1;
    localparam int LEVEL_TOP        = (1 << LEVEL_W) - 1;

    // Same layout as the output word: red in the lowest byte.
    typedef struct packed {
        t_level blue;
        t_level green;
        t_level red;
    } t_rgb;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;

    t_rgb rgb_pending[$];

    bit src_gaps_on;
    bit sink_gaps_on;
    bit sink_hold_req;

    int mismatch_count;
    int colors_sent;
    int colors_checked;
    int grey_count;
    int wide_hue_count;
    int input_stall_cycles;
    int cycle_count;

    hsv_to_rgb_converter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF_NS;
        i_clk = 1'b0;
        #CLK_HALF_NS;
    end

    // Behavioral conversion with the same truncating divisions by 255.
    function automatic t_rgb convert_hsv(input logic [HUE_W-1:0] hue, input t_level sat,
                                         input t_level val);
        int unsigned h, s, v, fs, frac, lvl_p, lvl_q, lvl_t;
        t_sector sector;
        t_rgb c;
        h  = hue;
        s  = sat;
        v  = val;
        fs = FULL_SCALE;
        if (s == 0) begin
            c.red   = val;
            c.green = val;
            c.blue  = val;
            return c;
        end
        sector = t_sector'(h / SECTOR_DEGREES);
        frac   = ((h % SECTOR_DEGREES) * fs) / SECTOR_DEGREES;
        lvl_p  = (v * (fs - s)) / fs;
        lvl_q  = (v * (fs - (s * frac) / fs)) / fs;
        lvl_t  = (v * (fs - (s * (fs - frac)) / fs)) / fs;
        case (sector)
            SEC_RED_YEL: begin
                c.red = val;             c.green = t_level'(lvl_t); c.blue = t_level'(lvl_p);
            end
            SEC_YEL_GRN: begin
                c.red = t_level'(lvl_q); c.green = val;             c.blue = t_level'(lvl_p);
            end
            SEC_GRN_CYN: begin
                c.red = t_level'(lvl_p); c.green = val;             c.blue = t_level'(lvl_t);
            end
            SEC_CYN_BLU: begin
                c.red = t_level'(lvl_p); c.green = t_level'(lvl_q); c.blue = val;
            end
            SEC_BLU_MAG: begin
                c.red = t_level'(lvl_t); c.green = t_level'(lvl_p); c.blue = val;
            end
            // Sector five and every out-of-range hue share this order.
            default: begin
                c.red = val;             c.green = t_level'(lvl_p); c.blue = t_level'(lvl_q);
            end
        endcase
        return c;
    endfunction

    // Offers one color at a falling edge and holds it until the block takes it.
    task automatic send_color(input logic [HUE_W-1:0] hue, input t_level sat,
                              input t_level val);
        int gap;
        @(negedge i_clk);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_DATA_W - HUE_W - 2 * LEVEL_W){1'b0}}, val, sat, hue};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_random_color();
        logic [HUE_W-1:0] hue;
        t_level sat, val;
        hue = ($urandom_range(0, 9) == 0) ? HUE_W'($urandom_range(HUE_LAST + 1, HUE_TOP))
                                          : HUE_W'($urandom_range(0, HUE_LAST));
        case ($urandom_range(0, 15))
            0:       sat = '0;
            1:       sat = t_level'(LEVEL_TOP);
            default: sat = t_level'($urandom_range(1, LEVEL_TOP));
        endcase
        case ($urandom_range(0, 15))
            0:       val = '0;
            1:       val = t_level'(LEVEL_TOP);
            default: val = t_level'($urandom);
        endcase
        send_color(hue, sat, val);
    endtask

    // Sector edges, both ends of each field, grey input and hues past 359.
    task automatic test_corner_colors();
        send_color(9'd0,   8'd255, 8'd255);
        send_color(9'd59,  8'd255, 8'd255);
        send_color(9'd60,  8'd255, 8'd255);
        send_color(9'd119, 8'd200, 8'd180);
        send_color(9'd120, 8'd255, 8'd255);
        send_color(9'd179, 8'd128, 8'd250);
        send_color(9'd180, 8'd255, 8'd255);
        send_color(9'd240, 8'd255, 8'd255);
        send_color(9'd299, 8'd77,  8'd99);
        send_color(9'd300, 8'd255, 8'd255);
        send_color(9'd359, 8'd255, 8'd255);
        send_color(9'd30,  8'd1,   8'd255);
        send_color(9'd90,  8'd255, 8'd1);
        send_color(9'd210, 8'd255, 8'd0);
        send_color(9'd150, 8'd0,   8'd0);
        send_color(9'd200, 8'd0,   8'd173);
        send_color(9'd511, 8'd0,   8'd255);
        send_color(9'd360, 8'd255, 8'd255);
        send_color(9'd420, 8'd170, 8'd230);
        send_color(9'd479, 8'd255, 8'd128);
        send_color(9'd511, 8'd255, 8'd255);
        send_color(9'd270, 8'd85,  8'd170);
        send_color(9'd45,  8'd170, 8'd85);
    endtask

    task automatic test_random_stream();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        repeat (RANDOM_WORDS) send_random_color();
    endtask

    // The sink stops for a long stretch while words keep coming, so the
    // pipeline fills and the input side must stall.
    task automatic test_output_stall();
        sink_hold_req = 1'b1;
        repeat (STALL_WORDS) send_random_color();
        wait (!sink_hold_req);
    endtask

    task automatic test_full_rate();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        repeat (FULL_RATE_WORDS) send_random_color();
    endtask

    // Output ready: random short stalls, or one long hold when requested.
    initial begin
        int n;
        int held;
        i_m_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                i_m_tready <= 1'b0;
                held = 0;
                while (held < SINK_HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
                sink_hold_req = 1'b0;
                i_m_tready <= 1'b1;
            end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 3);
                i_m_tready <= 1'b0;
                repeat (n) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Input words are predicted before output words are checked, so the order
    // inside one edge is fixed.
    always @(posedge i_clk) begin : word_monitor
        t_rgb want;
        t_rgb got;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                rgb_pending.push_back(convert_hsv(i_s_tdata[HUE_W-1:0],
                                                  i_s_tdata[HUE_W +: LEVEL_W],
                                                  i_s_tdata[HUE_W + LEVEL_W +: LEVEL_W]));
                colors_sent++;
                if (i_s_tdata[HUE_W +: LEVEL_W] == '0)
                    grey_count++;
                if (i_s_tdata[HUE_W-1:0] > HUE_LAST)
                    wide_hue_count++;
            end
            if (i_s_tvalid && !o_s_tready)
                input_stall_cycles++;
            if (o_m_tvalid && i_m_tready) begin
                got = t_rgb'(o_m_tdata);
                if (rgb_pending.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected output word r=%0d g=%0d b=%0d",
                                 $realtime, got.red, got.green, got.blue);
                end else begin
                    want = rgb_pending.pop_front();
                    colors_checked++;
                    if (got.red !== want.red || got.green !== want.green
                            || got.blue !== want.blue) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: mismatch expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding.",
                     cycle_count, rgb_pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        src_gaps_on   = 1'b0;
        sink_gaps_on  = 1'b0;
        sink_hold_req = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_colors();
        test_random_stream();
        test_output_stall();
        test_full_rate();

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (rgb_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d colors (%0d grey, %0d with hue past 359), checked %0d words.",
                 colors_sent, grey_count, wide_hue_count, colors_checked);
        $display("Input stalled on %0d cycles; %0d mismatches.",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
